/* rtl/core/bpw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpw_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUO_BITS      = 32;
	localparam int DIV_W         = 96;
	localparam int ROOT_BITS     = 32;

	localparam logic signed [64:0] SUM_MAX = 65'sd2147483647;
	localparam logic signed [64:0] SUM_MIN = -65'sd2147483648;

	typedef enum logic [2:0] {
		REG_B0X    = 3'd0,
		REG_B0Y    = 3'd1,
		REG_B1X    = 3'd2,
		REG_B1Y    = 3'd3,
		REG_WEIGHT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic               vld;
		logic               degen;
		logic               sat;
		logic               dneg;
		logic [63:0]        dmag;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
	} side_t;

	typedef struct packed {
		logic             neg;
		logic             big;
		logic [DIV_W-1:0] rem;
		logic [31:0]      quo;
	} div_t;

	typedef struct packed {
		logic        neg;
		logic        zero;
		logic [63:0] rad;
		logic [63:0] root;
	} sqr_t;

	function automatic logic [64:0] abs_diff(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] d;
		logic [64:0] m;
		d = {a[63], a} - {b[63], b};
		m = d[64] ? -d : d;
		return {d[64], m[63:0]};
	endfunction

	function automatic div_t div_step(input div_t d, input logic [63:0] den, input int b);
		logic [DIV_W-1:0] sh;
		div_t o;
		o  = d;
		sh = {{(DIV_W-64){1'b0}}, den} << b;
		if (d.rem >= sh) begin
			o.rem    = d.rem - sh;
			o.quo[b] = 1'b1;
		end
		return o;
	endfunction

	function automatic sqr_t sqrt_step(input sqr_t s, input int k);
		logic [63:0] bitv;
		logic [63:0] t;
		sqr_t o;
		o    = s;
		bitv = 64'd1 << (62 - 2 * k);
		t    = s.root + bitv;
		if (s.rad >= t) begin
			o.rad  = s.rad - t;
			o.root = (s.root >> 1) + bitv;
		end else begin
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	function automatic logic signed [63:0] scale_rnd(input logic signed [63:0] p, input int f);
		logic [63:0] m;
		m = p[63] ? 64'(-p) : 64'(p);
		m = (m + (64'd1 << (f - 1))) >> f;
		return p[63] ? $signed(-m) : $signed(m);
	endfunction

	function automatic logic [32:0] accum(input logic signed [31:0] s,
		input logic signed [63:0] c);
		logic signed [64:0] t;
		t = {{33{s[31]}}, s} + {c[63], c};
		if (t > SUM_MAX) begin
			return {1'b1, 32'h7FFF_FFFF};
		end
		if (t < SUM_MIN) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, t[31:0]};
	endfunction

	function automatic logic [32:0] clamp_quo(input logic neg, input logic big,
		input logic [31:0] quo);
		if (neg) begin
			if (big || quo > 32'h8000_0000) begin
				return {1'b1, 32'h8000_0000};
			end
			return {1'b0, quo};
		end
		if (big || quo[31]) begin
			return {1'b1, 32'h7FFF_FFFF};
		end
		return {1'b0, quo};
	endfunction

	function automatic logic [32:0] clamp_root(input logic neg, input logic zero,
		input logic [63:0] root);
		logic [31:0] r;
		r = root[31:0];
		if (zero) begin
			return 33'd0;
		end
		if (neg) begin
			if (root > 64'h8000_0000) begin
				return {1'b1, 32'h8000_0000};
			end
			return {1'b0, 32'(-r)};
		end
		if (root > 64'h7FFF_FFFF) begin
			return {1'b1, 32'h7FFF_FFFF};
		end
		return {1'b0, r};
	endfunction

endpackage

`default_nettype wire

/* rtl/core/barycentric_point_warp_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Barycentric point warp, fully pipelined.
// Input: pulse start with point_x/y/z and sum_in_x/y/z; the transfer happens
// at an edge where start is high and busy is low. busy stays low, so a new
// point may enter every cycle.
// Output: done is high for one cycle with sum_out_x/y/z, degenerate and
// saturated; the receiver takes it in that cycle and cannot hold it off.
// Throughput is one point per cycle. Depth is set by the two 32-stage
// restoring dividers (one quotient bit per stage) and the two 32-stage square
// roots (one root bit per stage), with multiply and clamp stages around them.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// write only while no point is in flight. Indexes beyond the weight register
// are dropped.
// Reset: arst_n clears the pipeline valid bits and loads the identity basis
// and unit weight.

module barycentric_point_warp_core
	import bpw_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	input  wire logic signed [31:0] sum_in_x,
	input  wire logic signed [31:0] sum_in_y,
	input  wire logic signed [31:0] sum_in_z,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic                    done,
	output logic signed [31:0]      sum_out_x,
	output logic signed [31:0]      sum_out_y,
	output logic signed [31:0]      sum_out_z,
	output logic                    degenerate,
	output logic                    saturated
);

	localparam int PIPE_LAT = 3 + QUO_BITS + 3 + ROOT_BITS + 4;
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	logic signed [31:0] b0x_q, b0y_q, b1x_q, b1y_q, weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0x_q    <= ONE;
			b0y_q    <= '0;
			b1x_q    <= '0;
			b1y_q    <= ONE;
			weight_q <= ONE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_B0X:    b0x_q    <= cfg_data;
				REG_B0Y:    b0y_q    <= cfg_data;
				REG_B1X:    b1x_q    <= cfg_data;
				REG_B1Y:    b1y_q    <= cfg_data;
				REG_WEIGHT: weight_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic               vld_s1;
	logic signed [63:0] pu1_s1, pu2_s1, pv1_s1, pv2_s1, pd1_s1, pd2_s1, pz_s1;
	logic signed [31:0] px_s1, py_s1, sx_s1, sy_s1, sz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		pu1_s1 <= b1y_q * point_x;
		pu2_s1 <= b1x_q * point_y;
		pv1_s1 <= b0x_q * point_y;
		pv2_s1 <= b0y_q * point_x;
		pd1_s1 <= b0x_q * b1y_q;
		pd2_s1 <= b0y_q * b1x_q;
		pz_s1  <= weight_q * point_z;
		px_s1  <= point_x;
		py_s1  <= point_y;
		sx_s1  <= sum_in_x;
		sy_s1  <= sum_in_y;
		sz_s1  <= sum_in_z;
	end

	side_t              side_s2;
	logic [64:0]        un_s2, vn_s2;
	logic signed [63:0] cz_s2;
	logic [64:0]        det_d;

	assign det_d = abs_diff(pd1_s1, pd2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2.vld   <= vld_s1;
			side_s2.degen <= det_d[63:0] == 64'd0;
			side_s2.sat   <= 1'b0;
			side_s2.dneg  <= det_d[64];
			side_s2.dmag  <= det_d[63:0];
			side_s2.px    <= px_s1;
			side_s2.py    <= py_s1;
			side_s2.sx    <= sx_s1;
			side_s2.sy    <= sy_s1;
			side_s2.sz    <= sz_s1;
		end
	end

	always_ff @(posedge clk) begin
		un_s2 <= abs_diff(pu1_s1, pu2_s1);
		vn_s2 <= abs_diff(pv1_s1, pv2_s1);
		cz_s2 <= scale_rnd(pz_s1, FRAC_BITS);
	end

	side_t dside_s [0:QUO_BITS];
	div_t  udiv_s  [0:QUO_BITS];
	div_t  vdiv_s  [0:QUO_BITS];

	logic [DIV_W-1:0] den_top, un_w, vn_w;
	logic [32:0]      zacc;
	side_t            side2_d;

	assign den_top = {{(DIV_W-64){1'b0}}, side_s2.dmag} << QUO_BITS;
	assign un_w    = {{(DIV_W-64){1'b0}}, un_s2[63:0]} << FRAC_BITS;
	assign vn_w    = {{(DIV_W-64){1'b0}}, vn_s2[63:0]} << FRAC_BITS;
	assign zacc    = accum(side_s2.sz, cz_s2);

	always_comb begin
		side2_d     = side_s2;
		side2_d.sz  = zacc[31:0];
		side2_d.sat = zacc[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QUO_BITS; j++) begin
				dside_s[j] <= '0;
				udiv_s[j]  <= '0;
				vdiv_s[j]  <= '0;
			end
		end else begin
			dside_s[0] <= side2_d;
			udiv_s[0]  <= '{neg: un_s2[64], big: un_w >= den_top, rem: un_w, quo: '0};
			vdiv_s[0]  <= '{neg: vn_s2[64], big: vn_w >= den_top, rem: vn_w, quo: '0};
			for (int j = 0; j < QUO_BITS; j++) begin
				dside_s[j+1] <= dside_s[j];
				udiv_s[j+1]  <= div_step(udiv_s[j], dside_s[j].dmag, QUO_BITS - 1 - j);
				vdiv_s[j+1]  <= div_step(vdiv_s[j], dside_s[j].dmag, QUO_BITS - 1 - j);
			end
		end
	end

	side_t       side_s4;
	logic [31:0] cu_s4, cv_s4;
	logic        cuneg_s4, cvneg_s4;
	logic [32:0] cu_d, cv_d;
	logic        dg_d;
	side_t       side4_d;

	assign dg_d = dside_s[QUO_BITS].degen;
	assign cu_d = clamp_quo(udiv_s[QUO_BITS].neg ^ dside_s[QUO_BITS].dneg,
		udiv_s[QUO_BITS].big, udiv_s[QUO_BITS].quo);
	assign cv_d = clamp_quo(vdiv_s[QUO_BITS].neg ^ dside_s[QUO_BITS].dneg,
		vdiv_s[QUO_BITS].big, vdiv_s[QUO_BITS].quo);

	always_comb begin
		side4_d     = dside_s[QUO_BITS];
		side4_d.sat = dside_s[QUO_BITS].sat || (!dg_d && (cu_d[32] || cv_d[32]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else begin
			side_s4 <= side4_d;
		end
	end

	always_ff @(posedge clk) begin
		cu_s4    <= dg_d ? 32'd0 : cu_d[31:0];
		cv_s4    <= dg_d ? 32'd0 : cv_d[31:0];
		cuneg_s4 <= (udiv_s[QUO_BITS].neg ^ dside_s[QUO_BITS].dneg) && cu_d[31:0] != 32'd0;
		cvneg_s4 <= (vdiv_s[QUO_BITS].neg ^ dside_s[QUO_BITS].dneg) && cv_d[31:0] != 32'd0;
	end

	side_t       side_s5;
	logic [63:0] squ_s5, sqv_s5, sqx_s5, sqy_s5;
	logic        uneg_s5, vneg_s5, uzero_s5, vzero_s5;
	logic [31:0] pxm, pym;

	assign pxm = side_s4.px[31] ? 32'(-side_s4.px) : side_s4.px;
	assign pym = side_s4.py[31] ? 32'(-side_s4.py) : side_s4.py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else begin
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		squ_s5   <= cu_s4 * cu_s4;
		sqv_s5   <= cv_s4 * cv_s4;
		sqx_s5   <= pxm * pxm;
		sqy_s5   <= pym * pym;
		uneg_s5  <= cuneg_s4;
		vneg_s5  <= cvneg_s4;
		uzero_s5 <= cu_s4 == 32'd0;
		vzero_s5 <= cv_s4 == 32'd0;
	end

	side_t sside_s [0:ROOT_BITS];
	sqr_t  usq_s   [0:ROOT_BITS];
	sqr_t  vsq_s   [0:ROOT_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ROOT_BITS; k++) begin
				sside_s[k] <= '0;
				usq_s[k]   <= '0;
				vsq_s[k]   <= '0;
			end
		end else begin
			sside_s[0] <= side_s5;
			usq_s[0]   <= '{neg: uneg_s5, zero: uzero_s5, rad: squ_s5 + sqx_s5, root: '0};
			vsq_s[0]   <= '{neg: vneg_s5, zero: vzero_s5, rad: sqv_s5 + sqy_s5, root: '0};
			for (int k = 0; k < ROOT_BITS; k++) begin
				sside_s[k+1] <= sside_s[k];
				usq_s[k+1]   <= sqrt_step(usq_s[k], k);
				vsq_s[k+1]   <= sqrt_step(vsq_s[k], k);
			end
		end
	end

	side_t              side_s7;
	logic signed [31:0] um_s7, vm_s7;
	logic [32:0]        um_d, vm_d;
	side_t              side7_d;

	assign um_d = clamp_root(usq_s[ROOT_BITS].neg, usq_s[ROOT_BITS].zero,
		usq_s[ROOT_BITS].root);
	assign vm_d = clamp_root(vsq_s[ROOT_BITS].neg, vsq_s[ROOT_BITS].zero,
		vsq_s[ROOT_BITS].root);

	always_comb begin
		side7_d     = sside_s[ROOT_BITS];
		side7_d.sat = sside_s[ROOT_BITS].sat || um_d[32] || vm_d[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s7 <= '0;
		end else begin
			side_s7 <= side7_d;
		end
	end

	always_ff @(posedge clk) begin
		um_s7 <= um_d[31:0];
		vm_s7 <= vm_d[31:0];
	end

	side_t              side_s8;
	logic signed [63:0] wu_s8, wv_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s8 <= '0;
		end else begin
			side_s8 <= side_s7;
		end
	end

	always_ff @(posedge clk) begin
		wu_s8 <= weight_q * um_s7;
		wv_s8 <= weight_q * vm_s7;
	end

	side_t              side_s9;
	logic signed [63:0] cx_s9, cy_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s9 <= '0;
		end else begin
			side_s9 <= side_s8;
		end
	end

	always_ff @(posedge clk) begin
		cx_s9 <= scale_rnd(wu_s8, FRAC_BITS);
		cy_s9 <= scale_rnd(wv_s8, FRAC_BITS);
	end

	logic [32:0] xacc, yacc;

	assign xacc = accum(side_s9.sx, cx_s9);
	assign yacc = accum(side_s9.sy, cy_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done       <= 1'b0;
			sum_out_x  <= '0;
			sum_out_y  <= '0;
			sum_out_z  <= '0;
			degenerate <= 1'b0;
			saturated  <= 1'b0;
		end else begin
			done       <= side_s9.vld;
			sum_out_x  <= xacc[31:0];
			sum_out_y  <= yacc[31:0];
			sum_out_z  <= side_s9.sz;
			degenerate <= side_s9.degen;
			saturated  <= side_s9.sat || xacc[32] || yacc[32];
		end
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##PIPE_LAT done)
		else $error("point transfer did not produce a result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PIPE_LAT))
		else $error("result without a point transfer");
	a_degen_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> sum_out_x == $past(sum_in_x, PIPE_LAT))
		else $error("degenerate basis changed the x sum");
`endif

endmodule

`default_nettype wire
